// ===== design/base64_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_defines.svh
// Assertion macros shared by the Base64 stream decoder modules.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// same-cycle implication
`define B64SD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64sd: same-cycle check failed");

// next-cycle implication
`define B64SD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64sd: next-cycle check failed");

`endif

// ===== design/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, constants and decode functions of the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SYMBOL = 2'd1,
        ERR_LENGTH = 2'd2
    } err_code_t;

    // configuration register indexes
    localparam logic CFG_URL_ALPHABET     = 1'b0;
    localparam logic CFG_PADDING_REQUIRED = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] VAL_62     = 6'd62;
    localparam logic [5:0] VAL_63     = 6'd63;

    // held symbol: pad mark and 6-bit value
    typedef struct packed {
        logic       pad;
        logic [5:0] val;
    } sym_t;

    localparam sym_t PAD_SYM = '{pad: 1'b1, val: 6'd0};

    typedef struct packed {
        logic keep;
        sym_t sym;
    } sym_class_t;

    // one decoded group, 1 to 3 results
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n_last;
        logic            has_data;
        err_code_t       err;
        logic            last;
    } grp_t;

    function automatic sym_class_t classify(input logic [7:0] c, input logic url);
        sym_class_t r;
        r.keep    = 1'b1;
        r.sym.pad = 1'b0;
        r.sym.val = 6'd0;
        case (c) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]: r.sym.val = 6'(c - CHAR_UPPER_A);
            [CHAR_LOWER_A:CHAR_LOWER_Z]: r.sym.val = 6'(c - CHAR_LOWER_A + LOWER_BASE);
            [CHAR_DIGIT_0:CHAR_DIGIT_9]: r.sym.val = 6'(c - CHAR_DIGIT_0 + DIGIT_BASE);
            CHAR_EQUALS:                 r.sym.pad = 1'b1;
            CHAR_PLUS:                   if (!url) r.sym.val = VAL_62; else r.keep = 1'b0;
            CHAR_SLASH:                  if (!url) r.sym.val = VAL_63; else r.keep = 1'b0;
            CHAR_MINUS:                  if (url) r.sym.val = VAL_62; else r.keep = 1'b0;
            CHAR_UNDER:                  if (url) r.sym.val = VAL_63; else r.keep = 1'b0;
            default:                     r.keep = 1'b0;
        endcase
        return r;
    endfunction

    function automatic grp_t decode_group(input sym_t s0, input sym_t s1,
                                          input sym_t s2, input sym_t s3);
        grp_t g;
        g.bytes[0] = {s0.val, s1.val[5:4]};
        g.bytes[1] = {s1.val[3:0], s2.val[5:2]};
        g.bytes[2] = {s2.val[1:0], s3.val};
        g.n_last   = s2.pad ? 2'd0 : (s3.pad ? 2'd1 : 2'd2);
        g.has_data = 1'b1;
        g.err      = (s0.pad || s1.pad) ? ERR_SYMBOL : ERR_NONE;
        g.last     = 1'b0;
        return g;
    endfunction

    function automatic grp_t marker(input err_code_t err);
        grp_t g;
        g.bytes    = '0;
        g.n_last   = 2'd0;
        g.has_data = 1'b0;
        g.err      = err;
        g.last     = 1'b1;
        return g;
    endfunction

endpackage

// ===== design/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 to bytes: one character in per cycle unless full, one out per pop.
// ----------------------------------------------------------------------------
// Input side is a queue: drive symbol/end_of_text with push; a transfer
// happens on a clock edge with push high and full low. Characters outside
// the selected alphabet and '=' are dropped; end_of_text still closes the text.
// Output side is a queue: while empty is low the oldest result sits on
// data_byte/byte_valid/error_code/final_result; pop with empty low takes it.
// A closed group's record passes through the record queue and current-group
// register before its first result reaches the output register. Input rate
// is one character per cycle while full is low; the output register gives
// one result per cycle while pop is high, and the record queue between intake
// and sequencer (QUEUE_DEPTH groups) absorbs bursts. When pop stays low,
// results wait in output register and queue; full rises once the queue fills.
// Reset clears held characters, queue and output; url_alphabet resets to 0,
// padding_required to 1. Write cfg_write/cfg_index/cfg_data only when idle.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] symbol,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic [1:0] error_code,
    output logic       final_result
);
    import b64sd_pkg::*;

    grp_t front_rec;
    grp_t queue_rec;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic back_pop;

    b64sd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (queue_full),
        .symbol      (symbol),
        .end_of_text (end_of_text),
        .rec_push    (front_push),
        .rec         (front_rec)
    );

    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_push),
        .wr_rec (front_rec),
        .full   (queue_full),
        .rd_en  (back_pop),
        .rd_rec (queue_rec),
        .empty  (queue_empty)
    );

    b64sd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (queue_rec),
        .rec_avail    (!queue_empty),
        .rec_pop      (back_pop),
        .pop          (pop),
        .empty        (empty),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .error_code   (error_code),
        .final_result (final_result)
    );

    assign full = queue_full;

endmodule

// ===== design/b64sd_front.sv =====
// ----------------------------------------------------------------------------
// b64sd_front
// Symbol intake: classifies characters, gathers groups of four and decodes
// each closed group into one record for the result queue.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64sd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic              cfg_data,
    input  logic              push,
    input  logic              full,
    input  logic [7:0]        symbol,
    input  logic              end_of_text,
    output logic              rec_push,
    output b64sd_pkg::grp_t   rec
);
    import b64sd_pkg::*;

    logic       url_alphabet_reg;
    logic       padding_required_reg;
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    sym_t       held_symbols_reg [3];

    sym_class_t cls;
    logic       accept;
    logic       group_full;
    logic       nothing_held;
    sym_t       g0, g1, g2, g3;

    assign cls          = classify(symbol, url_alphabet_reg);
    assign accept       = push && !full;
    assign group_full   = cls.keep && (held_count_reg == 2'd3);
    assign nothing_held = !cls.keep && (held_count_reg == 2'd0);
    assign rec_push     = accept && (group_full || end_of_text);

    always_comb
    begin
        g0 = (held_count_reg > 2'd0) ? held_symbols_reg[0] :
             (cls.keep ? cls.sym : PAD_SYM);
        g1 = (held_count_reg > 2'd1) ? held_symbols_reg[1] :
             ((held_count_reg == 2'd1 && cls.keep) ? cls.sym : PAD_SYM);
        g2 = (held_count_reg > 2'd2) ? held_symbols_reg[2] :
             ((held_count_reg == 2'd2 && cls.keep) ? cls.sym : PAD_SYM);
        g3 = group_full ? cls.sym : PAD_SYM;
    end

    always_comb
    begin
        if (!group_full && nothing_held)
        begin
            rec = marker(ERR_NONE);
        end
        else if (!group_full && padding_required_reg)
        begin
            rec = marker(ERR_LENGTH);
        end
        else
        begin
            rec      = decode_group(g0, g1, g2, g3);
            rec.last = end_of_text;
        end
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (group_full || end_of_text)
                held_count_next = 2'd0;
            else if (cls.keep)
                held_count_next = held_count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_alphabet_reg     <= 1'b0;
            padding_required_reg <= 1'b1;
            held_count_reg       <= 2'd0;
        end
        else
        begin
            held_count_reg <= held_count_next;
            if (cfg_write && cfg_index == CFG_URL_ALPHABET)
                url_alphabet_reg <= cfg_data;
            if (cfg_write && cfg_index == CFG_PADDING_REQUIRED)
                padding_required_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cls.keep && !group_full && !end_of_text)
            held_symbols_reg[held_count_reg] <= cls.sym;
    end

    `B64SD_ASSERT_NXT(fr_eot_clears, clk, rst_n, accept && end_of_text, held_count_reg == 2'd0)

endmodule

// ===== design/b64sd_queue.sv =====
// ----------------------------------------------------------------------------
// b64sd_queue
// Short record queue between the intake and the result sequencer.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64sd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  b64sd_pkg::grp_t wr_rec,
    output logic            full,
    input  logic            rd_en,
    output b64sd_pkg::grp_t rd_rec,
    output logic            empty
);
    import b64sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    grp_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full   = (count_reg == CNT_FULL);
    assign empty  = (count_reg == '0);
    assign rd_rec = store_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_rec;
    end

    `B64SD_ASSERT_IMP(q_no_overflow, clk, rst_n, wr_en, !full)
    `B64SD_ASSERT_IMP(q_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)

endmodule

// ===== design/b64sd_back.sv =====
// ----------------------------------------------------------------------------
// b64sd_back
// Result sequencer: splits each group record into its results and holds
// the oldest result in the output register.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64sd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  b64sd_pkg::grp_t rec,
    input  logic            rec_avail,
    output logic            rec_pop,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      data_byte,
    output logic            byte_valid,
    output logic [1:0]      error_code,
    output logic            final_result
);
    import b64sd_pkg::*;

    grp_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] data_byte_reg;
    logic       byte_valid_reg;
    err_code_t  error_code_reg;
    logic       final_result_reg;

    logic out_free, advance, cur_done, load;

    assign out_free = !out_valid_reg || pop;
    assign advance  = out_free && cur_valid_reg;
    assign cur_done = advance && (idx_reg == cur_reg.n_last);
    assign load     = rec_avail && (!cur_valid_reg || cur_done);
    assign rec_pop  = load;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 2'd1;
        end
        if (cur_done)
            cur_valid_next = 1'b0;
        if (load)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= rec;
        if (advance)
        begin
            data_byte_reg    <= cur_reg.has_data ? cur_reg.bytes[idx_reg] : 8'd0;
            byte_valid_reg   <= cur_reg.has_data;
            error_code_reg   <= cur_reg.err;
            final_result_reg <= cur_reg.last && (idx_reg == cur_reg.n_last);
        end
    end

    assign empty        = !out_valid_reg;
    assign data_byte    = data_byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign error_code   = error_code_reg;
    assign final_result = final_result_reg;

    `B64SD_ASSERT_IMP(bk_marker_zero, clk, rst_n, out_valid_reg && !byte_valid_reg, data_byte_reg == 8'd0)
    `B64SD_ASSERT_IMP(bk_length_final, clk, rst_n, out_valid_reg && error_code_reg == ERR_LENGTH, final_result_reg && !byte_valid_reg)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams Base64 text through base64_stream_decoder under random burst
// gaps and output stalls. A scoreboard decodes every accepted character in
// parallel and checks each popped byte, error code and end-of-text flag in
// order, across all alphabet and padding modes.
// ----------------------------------------------------------------------------
module tb;

    import b64sd_pkg::*;

    localparam int         CYCLE_LIMIT          = 200000;
    localparam logic [7:0] SKIP_CODE            = 8'h80;
    localparam logic [6:0] PAD_HELD             = 7'h40;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        err_code_t  err;
        logic       last;
    } b64_result_t;

    class b64_scoreboard;
        bit          url_mode;
        bit          pad_strict;
        int unsigned held_n;
        logic [6:0]  held [3];
        b64_result_t decoded_q [$];
        int          mismatches;

        function new();
            url_mode   = 1'b0;
            pad_strict = 1'b1;
            held_n     = 0;
            mismatches = 0;
        endfunction

        // {skip, pad, value}
        function logic [7:0] sym_code(input logic [7:0] c);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c - CHAR_UPPER_A;
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return c - CHAR_LOWER_A + LOWER_BASE;
            if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return c - CHAR_DIGIT_0 + DIGIT_BASE;
            if (c == CHAR_EQUALS) return {1'b0, PAD_HELD};
            if (url_mode && c == CHAR_MINUS) return {2'b00, VAL_62};
            if (url_mode && c == CHAR_UNDER) return {2'b00, VAL_63};
            if (!url_mode && c == CHAR_PLUS) return {2'b00, VAL_62};
            if (!url_mode && c == CHAR_SLASH) return {2'b00, VAL_63};
            return SKIP_CODE;
        endfunction

        function void add_byte(input logic [7:0] d, input logic v, input err_code_t e);
            b64_result_t r;
            r.data  = d;
            r.valid = v;
            r.err   = e;
            r.last  = 1'b0;
            decoded_q.push_back(r);
        endfunction

        function void decode_quad(input logic [6:0] q0, input logic [6:0] q1,
                                  input logic [6:0] q2, input logic [6:0] q3);
            logic [5:0] v0, v1, v2, v3;
            err_code_t  e;
            v0 = q0[6] ? 6'd0 : q0[5:0];
            v1 = q1[6] ? 6'd0 : q1[5:0];
            v2 = q2[5:0];
            v3 = q3[5:0];
            e  = (q0[6] || q1[6]) ? ERR_SYMBOL : ERR_NONE;
            add_byte({v0, v1[5:4]}, 1'b1, e);
            if (q2[6]) return;
            add_byte({v1[3:0], v2[5:2]}, 1'b1, e);
            if (q3[6]) return;
            add_byte({v2[1:0], v3}, 1'b1, e);
        endfunction

        function void note_symbol(input logic [7:0] c, input logic eot);
            logic [7:0]  code;
            int          n0;
            b64_result_t r;
            code = sym_code(c);
            n0   = decoded_q.size();
            if (code != SKIP_CODE) begin
                if (held_n < 3) begin
                    held[held_n] = code[6:0];
                    held_n++;
                end
                else begin
                    decode_quad(held[0], held[1], held[2], code[6:0]);
                    held_n = 0;
                end
            end
            if (eot) begin
                if (held_n != 0) begin
                    if (pad_strict)
                        add_byte(8'h00, 1'b0, ERR_LENGTH);
                    else
                        decode_quad(held[0], (held_n > 1) ? held[1] : PAD_HELD,
                                    (held_n > 2) ? held[2] : PAD_HELD, PAD_HELD);
                    held_n = 0;
                end
                if (decoded_q.size() == n0)
                    add_byte(8'h00, 1'b0, ERR_NONE);
                r = decoded_q.pop_back();
                r.last = 1'b1;
                decoded_q.push_back(r);
            end
        endfunction

        function void check_result(input logic [7:0] d, input logic v,
                                   input logic [1:0] e, input logic f);
            b64_result_t want;
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %02h valid %0d err %0d final %0d",
                             d, v, e, f);
                return;
            end
            want = decoded_q.pop_front();
            if (want.data !== d || want.valid !== v || want.err !== e || want.last !== f) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %02h/%0d/%0d/%0d, got %02h/%0d/%0d/%0d",
                             want.data, want.valid, want.err, want.last, d, v, e, f);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_write   = 1'b0;
    logic       cfg_index   = 1'b0;
    logic       cfg_data    = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    logic [7:0] symbol      = 8'h00;
    logic       end_of_text = 1'b0;
    logic       empty;
    logic       pop         = 1'b0;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] error_code;
    logic       final_result;

    b64_scoreboard sb = new();
    int burst_left   = 0;
    int kept_count   = 0;
    int hold_request = 0;

    base64_stream_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .symbol       (symbol),
        .end_of_text  (end_of_text),
        .empty        (empty),
        .pop          (pop),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .error_code   (error_code),
        .final_result (final_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb failed");
        $finish;
    end

    // receiver: stall pattern changes in random stretches, plus requested hold-offs
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        bit take;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(data_byte, byte_valid, error_code, final_result);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       take = 1'b1;
                    1:       take = ($urandom_range(0, 3) != 0);
                    2:       take = ($urandom_range(0, 3) == 0);
                    default: take = ~pop;
                endcase
            end
            pop <= take;
        end
    end

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        if (v < LOWER_BASE) return CHAR_UPPER_A + v;
        if (v < DIGIT_BASE) return CHAR_LOWER_A + v - LOWER_BASE;
        if (v == VAL_62) return sb.url_mode ? CHAR_MINUS : CHAR_PLUS;
        if (v == VAL_63) return sb.url_mode ? CHAR_UNDER : CHAR_SLASH;
        return CHAR_DIGIT_0 + v - DIGIT_BASE;
    endfunction

    function automatic logic [7:0] skip_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (sb.sym_code(c) != SKIP_CODE);
        return c;
    endfunction

    task automatic push_item(input logic [7:0] s, input logic e);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push        <= 1'b1;
        symbol      <= s;
        end_of_text <= e;
        @(posedge clk);
        while (full) @(posedge clk);
        if (sb.sym_code(s) != SKIP_CODE)
            kept_count++;
        sb.note_symbol(s, e);
        burst_left--;
    endtask

    task automatic send_string(input string txt);
        for (int i = 0; i < txt.len(); i++)
            push_item(txt[i], i == txt.len() - 1);
    endtask

    // mostly well-formed groups with random content, some noise
    task automatic send_random_text();
        logic [7:0] core [$];
        int         n;
        bit         trailing_skip;
        if ($urandom_range(0, 9) < 7)
        begin
            repeat ($urandom_range(0, 4) * 4)
                core.push_back(alpha_char(6'($urandom_range(0, 63))));
            case ($urandom_range(0, 4))
                1: n = 2;
                2: n = 3;
                3: n = $urandom_range(1, 3);
                4: n = 2;
                default: n = 0;
            endcase
            repeat (n) core.push_back(alpha_char(6'($urandom_range(0, 63))));
            if (n != 0 && core.size() % 4 != 0 && $urandom_range(0, 3) != 0)
                while (core.size() % 4 != 0) core.push_back(CHAR_EQUALS);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: core.push_back(8'($urandom_range(0, 255)));
                    3:       core.push_back(CHAR_EQUALS);
                    default: core.push_back(alpha_char(6'($urandom_range(0, 63))));
                endcase
            end
        end
        trailing_skip = ($urandom_range(0, 5) == 0) || (core.size() == 0);
        for (int i = 0; i < core.size(); i++)
        begin
            if ($urandom_range(0, 7) == 0)
                push_item(skip_char(), 1'b0);
            push_item(core[i], !trailing_skip && i == core.size() - 1);
        end
        if (trailing_skip)
            push_item(skip_char(), 1'b1);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.decoded_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_mode(input logic url, input logic pad);
        cfg_write <= 1'b1;
        cfg_index <= CFG_URL_ALPHABET;
        cfg_data  <= url;
        @(posedge clk);
        cfg_index <= CFG_PADDING_REQUIRED;
        cfg_data  <= pad;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.url_mode   = url;
        sb.pad_strict = pad;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: standard alphabet, padding required
        send_string("AZaz");
        send_string("09+/");
        send_string("=ABC");
        send_string("A=B=");
        send_string("AB=C");
        send_string("AB");
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        while (kept_count < 80) send_random_text();
        drain();

        // long receiver hold-off while the sender keeps pushing
        hold_request = 300;
        for (int i = 0; i < 60; i++)
            push_item(alpha_char(6'($urandom_range(0, 63))), i == 59);
        drain();

        set_mode(1'b1, 1'b0);
        send_string("-_+A");
        send_string("B");
        send_string("AB");
        while (kept_count < 180) send_random_text();
        drain();

        set_mode(1'b0, 1'b0);
        while (kept_count < 240) send_random_text();
        drain();

        set_mode(1'b1, 1'b1);
        while (kept_count < 300) send_random_text();
        drain();

        if (sb.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== base64_stream_decoder.f =====
+incdir+design
design/b64sd_pkg.sv
design/b64sd_front.sv
design/b64sd_queue.sv
design/b64sd_back.sv
design/base64_stream_decoder.sv
bench/tb.sv
